>>> hdl/llsa_pkg.sv
`timescale 1ns / 1ps
// Package for the least-loaded server assignment unit.
// Holds the per-cell control bundle and the sequencer state type; no dependencies.
package llsa_pkg;

    typedef struct packed {
        logic clear;    // zero the load (start of a new batch)
        logic update;   // add the service time to this cell's load
        logic active;   // cell takes part in the minimum search
        logic first;    // head of the chain: always take own load
    } llsa_cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } llsa_state_t;

endpackage

>>> hdl/llsa_cell.sv
`timescale 1ns / 1ps
// One server cell: holds that server's load and one stage of the minimum search.
// Depends on llsa_pkg for the control bundle.
module llsa_cell
    import llsa_pkg::*;
#(
    parameter int LOAD_WIDTH = 32,
    parameter int IDX_W      = 3,
    parameter int CELL_IDX   = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  llsa_cell_ctrl_t       ctrl,
    input  logic [15:0]           service_time,
    input  logic [LOAD_WIDTH-1:0] in_load,
    input  logic [IDX_W-1:0]      in_idx,
    output logic [LOAD_WIDTH-1:0] out_load,
    output logic [IDX_W-1:0]      out_idx,
    output logic                  sat
);

    localparam int SUM_W = ((LOAD_WIDTH > 16) ? LOAD_WIDTH : 16) + 1;

    logic [LOAD_WIDTH-1:0] load_reg, load_next;
    logic [LOAD_WIDTH-1:0] tok_load_reg, tok_load_next;
    logic [IDX_W-1:0]      tok_idx_reg, tok_idx_next;
    logic [SUM_W-1:0]      sum;
    logic                  ovf;
    logic                  take;

    // Saturating add of the service time.
    assign sum = SUM_W'(load_reg) + SUM_W'(service_time);
    assign ovf = |sum[SUM_W-1:LOAD_WIDTH];
    assign sat = ctrl.update & ovf;

    always_comb begin
        load_next = load_reg;
        if (ctrl.clear) begin
            load_next = '0;
        end else if (ctrl.update) begin
            load_next = ovf ? {LOAD_WIDTH{1'b1}} : sum[LOAD_WIDTH-1:0];
        end
    end

    // Strictly smaller load takes over; ties keep the lower index upstream.
    assign take = ctrl.active & (ctrl.first | (load_reg < in_load));

    always_comb begin
        tok_load_next = take ? load_reg : in_load;
        tok_idx_next  = take ? IDX_W'(CELL_IDX) : in_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
        end else begin
            load_reg <= load_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_load_reg <= tok_load_next;
        tok_idx_reg  <= tok_idx_next;
    end

    assign out_load = tok_load_reg;
    assign out_idx  = tok_idx_reg;

endmodule

>>> hdl/least_loaded_server_assign_unit.sv
`timescale 1ns / 1ps
// Top level of the least-loaded server assignment unit.
// Depends on llsa_pkg and llsa_cell.
//
// Each input beat is one job with its service time. The unit keeps one load
// per server in a chain of MAX_SERVERS cells. After a job is accepted, a
// search token walks the chain one cell per cycle, keeping the smallest load
// seen among the servers in use (lowest index on a tie); the chosen cell then
// adds the service time to its load, saturating at 2^LOAD_WIDTH - 1, and the
// result beat (server index, job number in the batch, saturation flag) is
// loaded into the output register. A job passes through accept, the token's
// walk across every cell of the chain and the update; a new job is taken
// only after the previous update, which waits while the output register
// holds an untaken result. The output register lets the next job be
// accepted while the previous result still waits. new_batch zeroes all
// loads and the job counter at acceptance, before the search. servers_in_use
// must be written through the cfg port only while idle; the unit does not
// enforce this. 0 acts as one server and values above MAX_SERVERS act as
// MAX_SERVERS. Loads of servers outside the active range are kept and ignored.
module least_loaded_server_assign_unit
    import llsa_pkg::*;
#(
    parameter int MAX_SERVERS = 8,
    parameter int LOAD_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // job input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_service_time,
    input  logic        s_new_batch,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_server_index,
    output logic [15:0] m_job_number,
    output logic        m_load_saturated
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = IDX_W;

    llsa_state_t state_reg, state_next;

    logic [3:0]       servers_in_use_reg;
    logic [15:0]      service_time_reg, service_time_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [15:0]      job_cnt_reg, job_cnt_next;
    logic [15:0]      job_cnt_inc;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_server_index_reg, m_server_index_next;
    logic [15:0] m_job_number_reg, m_job_number_next;
    logic        m_load_saturated_reg, m_load_saturated_next;

    logic        s_fire;
    logic        out_free;
    logic        upd_fire;

    // chain wiring: element i is the token fed into cell i, element MAX_SERVERS the tail
    logic [LOAD_WIDTH-1:0] chain_load [MAX_SERVERS+1];
    logic [IDX_W-1:0]      chain_idx  [MAX_SERVERS+1];
    logic [MAX_SERVERS-1:0] cell_sat;
    llsa_cell_ctrl_t        cell_ctrl [MAX_SERVERS];

    logic [IDX_W-1:0] best_idx;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;
    assign best_idx  = chain_idx[MAX_SERVERS];
    assign job_cnt_inc = (job_cnt_reg == 16'hFFFF) ? job_cnt_reg : job_cnt_reg + 16'd1;

    // head of the chain: cell 0 always takes its own load, so this token is unused
    assign chain_load[0] = '0;
    assign chain_idx[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SERVERS; gi++) begin : g_cell
            always_comb begin
                cell_ctrl[gi].clear  = s_fire & s_new_batch;
                cell_ctrl[gi].update = upd_fire & (best_idx == IDX_W'(gi));
                cell_ctrl[gi].active = (gi == 0) || (32'(servers_in_use_reg) > 32'(gi));
                cell_ctrl[gi].first  = (gi == 0);
            end

            llsa_cell #(
                .LOAD_WIDTH (LOAD_WIDTH),
                .IDX_W      (IDX_W),
                .CELL_IDX   (gi)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (cell_ctrl[gi]),
                .service_time (service_time_reg),
                .in_load      (chain_load[gi]),
                .in_idx       (chain_idx[gi]),
                .out_load     (chain_load[gi+1]),
                .out_idx      (chain_idx[gi+1]),
                .sat          (cell_sat[gi])
            );
        end
    endgenerate

    // Sequencer: accept, let the token cross every cell, then update and emit.
    always_comb begin
        state_next            = state_reg;
        scan_cnt_next         = scan_cnt_reg;
        service_time_next     = service_time_reg;
        job_cnt_next          = job_cnt_reg;
        upd_fire              = 1'b0;
        m_valid_next          = m_valid_reg & ~m_ready;
        m_server_index_next   = m_server_index_reg;
        m_job_number_next     = m_job_number_reg;
        m_load_saturated_next = m_load_saturated_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    service_time_next = s_service_time;
                    scan_cnt_next     = '0;
                    if (s_new_batch) begin
                        job_cnt_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // hold until the token has reached the tail of the chain
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(MAX_SERVERS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // wait for a free output slot, then apply the load and emit the beat
                if (out_free) begin
                    upd_fire              = 1'b1;
                    job_cnt_next          = job_cnt_inc;
                    m_valid_next          = 1'b1;
                    m_server_index_next   = 3'(best_idx);
                    m_job_number_next     = job_cnt_inc;
                    m_load_saturated_next = |cell_sat;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            scan_cnt_reg       <= '0;
            job_cnt_reg        <= '0;
            m_valid_reg        <= 1'b0;
            servers_in_use_reg <= 4'd8;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            job_cnt_reg  <= job_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                servers_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        service_time_reg     <= service_time_next;
        m_server_index_reg   <= m_server_index_next;
        m_job_number_reg     <= m_job_number_next;
        m_load_saturated_reg <= m_load_saturated_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_server_index   = m_server_index_reg;
    assign m_job_number     = m_job_number_reg;
    assign m_load_saturated = m_load_saturated_reg;

endmodule
